// File: rtl/core/cbt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the code breakpoint table.
// No dependencies; used by cbt_mem and code_breakpoint_table.
package cbt_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int ADDR_W        = 8;
    localparam int COUNT_OUT_W   = 5;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_CHECK  = 2'd3
    } cmd_t;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

endpackage

// File: rtl/core/cbt_mem.sv
`timescale 1ns / 1ps
// Breakpoint address store: one write port, one read port with registered data.
// Depends on cbt_pkg for the address width.
module cbt_mem #(
    parameter int DEPTH = cbt_pkg::DEFAULT_DEPTH,
    parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [IW-1:0]             waddr,
    input  logic [cbt_pkg::ADDR_W-1:0] wdata,
    input  logic [IW-1:0]             raddr,
    output logic [cbt_pkg::ADDR_W-1:0] rdata
);

    logic [cbt_pkg::ADDR_W-1:0] mem [DEPTH];
    logic [cbt_pkg::ADDR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/code_breakpoint_table.sv
`timescale 1ns / 1ps
// Code breakpoint table: command sequencer with one shared compare/increment unit.
// Depends on cbt_pkg and cbt_mem.
//
// Usage: drive cmd and address with start high while busy is low; that edge
// accepts the transaction. Each transaction returns exactly one result, shown
// on status, hit, hit_address and entry_count for one cycle while done is high.
// The receiver cannot stall; results must be taken as they appear.
// Clear, and add/delete/check on an empty table, answer in the cycle
// after acceptance. Otherwise the table is scanned by one comparator fed from
// the single memory read port, each entry examined passing through ST_READ
// then ST_COMP, until a match or the last entry; done is then registered.
// Delete then moves each later entry down, through ST_SHIFT_RD and ST_SHIFT_WR.
// busy stays high throughout the scan and the shift, and a new transaction
// may be started in the cycle that done is shown.
// Reset empties the table (count to zero) and returns the sequencer to idle;
// stored addresses are left as they are and are never read before written.
module code_breakpoint_table #(
    parameter int TABLE_DEPTH = cbt_pkg::DEFAULT_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     cmd,
    input  logic [cbt_pkg::ADDR_W-1:0]     address,
    output logic                           done,
    output logic                           status,
    output logic                           hit,
    output logic [cbt_pkg::ADDR_W-1:0]     hit_address,
    output logic [cbt_pkg::COUNT_OUT_W-1:0] entry_count
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COMP,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } state_t;

    state_t                              state_reg, state_next;
    cbt_pkg::cmd_t                       cmd_reg, cmd_next;
    logic [cbt_pkg::ADDR_W-1:0]          addr_reg, addr_next;
    logic [CW-1:0]                       idx_reg, idx_next;
    logic [CW-1:0]                       count_reg, count_next;
    logic                                done_reg, done_next;
    logic                                status_reg, status_next;
    logic                                hit_reg, hit_next;
    logic [cbt_pkg::ADDR_W-1:0]          hit_address_reg, hit_address_next;
    logic [cbt_pkg::COUNT_OUT_W-1:0]     entry_count_reg, entry_count_next;

    logic                                mem_we;
    logic [IW-1:0]                       mem_waddr;
    logic [cbt_pkg::ADDR_W-1:0]          mem_wdata;
    logic [IW-1:0]                       mem_raddr;
    logic [cbt_pkg::ADDR_W-1:0]          mem_rdata;

    cbt_pkg::cmd_t                       op;
    logic [cbt_pkg::ADDR_W-1:0]          key;
    logic [CW-1:0]                       idx_plus1;
    logic                                match;
    logic                                miss;
    logic                                found;
    logic                                fin;

    cbt_mem #(
        .DEPTH (TABLE_DEPTH),
        .IW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Shared unit: one address compare and one index increment
    assign idx_plus1 = idx_reg + CW'(1);
    assign match     = (mem_rdata == key);

    assign op  = (state_reg == ST_IDLE) ? cbt_pkg::cmd_t'(cmd) : cmd_reg;
    assign key = (state_reg == ST_IDLE) ? address : addr_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        addr_next        = addr_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        hit_next         = hit_reg;
        hit_address_next = hit_address_reg;
        entry_count_next = entry_count_reg;
        mem_we           = 1'b0;
        mem_waddr        = count_reg[IW-1:0];
        mem_wdata        = key;
        mem_raddr        = idx_reg[IW-1:0];
        miss             = 1'b0;
        found            = 1'b0;
        fin              = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = op;
                    addr_next = address;
                    idx_next  = '0;
                    if (op == cbt_pkg::CMD_CLEAR)
                    begin
                        count_next  = '0;
                        status_next = cbt_pkg::STATUS_DONE;
                        hit_next    = 1'b0;
                        fin         = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        miss = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_COMP;
            end
            ST_COMP:
            begin
                if (match)
                begin
                    found = 1'b1;
                end
                else if (idx_plus1 == count_reg)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    idx_next   = idx_plus1;
                    state_next = ST_READ;
                end
            end
            ST_SHIFT_RD:
            begin
                mem_raddr  = idx_plus1[IW-1:0];
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                // Move the later entry down one place
                mem_we    = 1'b1;
                mem_waddr = idx_reg[IW-1:0];
                mem_wdata = mem_rdata;
                idx_next  = idx_plus1;
                if ((idx_plus1 + CW'(1)) == count_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = cbt_pkg::STATUS_DONE;
                    hit_next    = 1'b0;
                    fin         = 1'b1;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (miss)
        begin
            hit_next = 1'b0;
            fin      = 1'b1;
            case (op)
                cbt_pkg::CMD_ADD:
                begin
                    if (count_reg >= CW'(TABLE_DEPTH))
                    begin
                        status_next = cbt_pkg::STATUS_REFUSED;
                    end
                    else
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = count_reg[IW-1:0];
                        mem_wdata   = key;
                        count_next  = count_reg + CW'(1);
                        status_next = cbt_pkg::STATUS_DONE;
                    end
                end
                cbt_pkg::CMD_DELETE:
                begin
                    status_next = cbt_pkg::STATUS_REFUSED;
                end
                default:
                begin
                    status_next = cbt_pkg::STATUS_DONE;
                end
            endcase
        end

        if (found)
        begin
            hit_next = 1'b0;
            case (op)
                cbt_pkg::CMD_ADD:
                begin
                    status_next = cbt_pkg::STATUS_REFUSED;
                    fin         = 1'b1;
                end
                cbt_pkg::CMD_DELETE:
                begin
                    if (idx_plus1 == count_reg)
                    begin
                        count_next  = count_reg - CW'(1);
                        status_next = cbt_pkg::STATUS_DONE;
                        fin         = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_SHIFT_RD;
                    end
                end
                default:
                begin
                    status_next = cbt_pkg::STATUS_DONE;
                    hit_next    = 1'b1;
                    fin         = 1'b1;
                end
            endcase
        end

        if (fin)
        begin
            done_next        = 1'b1;
            state_next       = ST_IDLE;
            hit_address_next = hit_next ? mem_rdata : '0;
            entry_count_next = cbt_pkg::COUNT_OUT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= cbt_pkg::CMD_ADD;
            addr_reg        <= '0;
            idx_reg         <= '0;
            count_reg       <= '0;
            done_reg        <= 1'b0;
            status_reg      <= cbt_pkg::STATUS_DONE;
            hit_reg         <= 1'b0;
            hit_address_reg <= '0;
            entry_count_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_reg         <= cmd_next;
            addr_reg        <= addr_next;
            idx_reg         <= idx_next;
            count_reg       <= count_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            hit_reg         <= hit_next;
            hit_address_reg <= hit_address_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign hit         = hit_reg;
    assign hit_address = hit_address_reg;
    assign entry_count = entry_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobed while sequencer busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither scanned nor answered");

    a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> (status_reg == cbt_pkg::STATUS_DONE))
        else $error("hit reported with refused status");

    a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !hit_reg) |-> (hit_address_reg == '0))
        else $error("hit address not zero without a hit");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for code_breakpoint_table: directed and random commands.
// Depends on cbt_pkg and the code_breakpoint_table RTL.
module tb;

    localparam int DEPTH       = cbt_pkg::DEFAULT_DEPTH;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN       = 4 * DEPTH + 16;
    localparam int RANDOM_CMDS = 1500;

    typedef struct packed {
        logic                            status;
        logic                            hit;
        logic [cbt_pkg::ADDR_W-1:0]      hit_address;
        logic [cbt_pkg::COUNT_OUT_W-1:0] entry_count;
    } bp_result_t;

    class breakpoint_scoreboard;
        logic [cbt_pkg::ADDR_W-1:0] held_addresses [DEPTH];
        int                         held_count;
        bp_result_t                 pending_results [$];
        int                         errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        function int find_held(logic [cbt_pkg::ADDR_W-1:0] a);
            for (int i = 0; i < held_count; i++)
            begin
                if (held_addresses[i] == a)
                    return i;
            end
            return -1;
        endfunction

        // Work out the answer to an accepted transaction and update the table copy.
        function void note_command(cbt_pkg::cmd_t c, logic [cbt_pkg::ADDR_W-1:0] a);
            bp_result_t r;
            int         k;
            r = '0;
            r.status = cbt_pkg::STATUS_DONE;
            k = find_held(a);
            case (c)
                cbt_pkg::CMD_ADD:
                begin
                    if (held_count >= DEPTH || k >= 0)
                        r.status = cbt_pkg::STATUS_REFUSED;
                    else
                    begin
                        held_addresses[held_count] = a;
                        held_count++;
                    end
                end
                cbt_pkg::CMD_DELETE:
                begin
                    if (k < 0)
                        r.status = cbt_pkg::STATUS_REFUSED;
                    else
                    begin
                        for (int i = k; i + 1 < held_count; i++)
                            held_addresses[i] = held_addresses[i + 1];
                        held_count--;
                    end
                end
                cbt_pkg::CMD_CLEAR:
                    held_count = 0;
                cbt_pkg::CMD_CHECK:
                begin
                    if (k >= 0)
                    begin
                        r.hit         = 1'b1;
                        r.hit_address = held_addresses[k];
                    end
                end
            endcase
            r.entry_count = cbt_pkg::COUNT_OUT_W'(held_count);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(bp_result_t got);
            bp_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            exp_r = pending_results.pop_front();
            compare_field("status", exp_r.status, got.status);
            compare_field("hit", exp_r.hit, got.hit);
            compare_field("hit_address", exp_r.hit_address, got.hit_address);
            compare_field("entry_count", exp_r.entry_count, got.entry_count);
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [1:0]                      cmd;
    logic [cbt_pkg::ADDR_W-1:0]      address;
    logic                            done;
    logic                            status;
    logic                            hit;
    logic [cbt_pkg::ADDR_W-1:0]      hit_address;
    logic [cbt_pkg::COUNT_OUT_W-1:0] entry_count;

    breakpoint_scoreboard sb = new();
    int                   burst_left;
    int                   pool_base;
    int                   add_pct;
    int                   idle_cycles;

    code_breakpoint_table #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .address     (address),
        .done        (done),
        .status      (status),
        .hit         (hit),
        .hit_address (hit_address),
        .entry_count (entry_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Monitor: note accepted transactions first, then check any result shown.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(cbt_pkg::cmd_t'(cmd), address);
            if (done)
                sb.check_result({status, hit, hit_address, entry_count});
        end
    end

    // Watchdog on cycles with no transaction accepted and no result shown.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Hold start high until the block takes the transaction.
    task automatic send_command(cbt_pkg::cmd_t c, logic [cbt_pkg::ADDR_W-1:0] a);
        start   <= 1'b1;
        cmd     <= c;
        address <= a;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic issue(cbt_pkg::cmd_t c, logic [cbt_pkg::ADDR_W-1:0] a);
        int gap;
        if (burst_left == 0)
        begin
            // Mostly short gaps, some long, some none at all.
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_command(c, a);
    endtask

    function automatic logic [cbt_pkg::ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return cbt_pkg::ADDR_W'($urandom_range(0, 255));
        if (r < 40 && sb.held_count > 0)
            return sb.held_addresses[$urandom_range(0, sb.held_count - 1)];
        return cbt_pkg::ADDR_W'(pool_base + $urandom_range(0, DEPTH + 5));
    endfunction

    function automatic cbt_pkg::cmd_t pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < add_pct)
            return cbt_pkg::CMD_ADD;
        if (r < add_pct + 25)
            return cbt_pkg::CMD_DELETE;
        if (r < add_pct + 28)
            return cbt_pkg::CMD_CLEAR;
        return cbt_pkg::CMD_CHECK;
    endfunction

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= cbt_pkg::CMD_ADD;
        address     <= '0;
        idle_cycles <= 0;
        burst_left  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty table, extremes of the address, duplicates and misses.
        issue(cbt_pkg::CMD_CHECK, 8'h00);
        issue(cbt_pkg::CMD_DELETE, 8'hFF);
        issue(cbt_pkg::CMD_ADD, 8'h00);
        issue(cbt_pkg::CMD_ADD, 8'hFF);
        issue(cbt_pkg::CMD_ADD, 8'hFF);
        issue(cbt_pkg::CMD_CHECK, 8'hFF);
        issue(cbt_pkg::CMD_CHECK, 8'h80);
        issue(cbt_pkg::CMD_DELETE, 8'h00);
        issue(cbt_pkg::CMD_DELETE, 8'h00);
        issue(cbt_pkg::CMD_CLEAR, 8'h5A);
        // Fill the table, then overfill it.
        for (int i = 0; i < DEPTH; i++)
            issue(cbt_pkg::CMD_ADD, cbt_pkg::ADDR_W'(i * 17));
        issue(cbt_pkg::CMD_ADD, 8'h01);
        issue(cbt_pkg::CMD_CHECK, 8'hFF);
        // Drop from the middle, the front and the back.
        issue(cbt_pkg::CMD_DELETE, 8'h77);
        issue(cbt_pkg::CMD_DELETE, 8'h00);
        issue(cbt_pkg::CMD_DELETE, 8'hFF);
        issue(cbt_pkg::CMD_CHECK, 8'h88);
        issue(cbt_pkg::CMD_CLEAR, 8'hA5);

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 150 == 0)
            begin
                pool_base = $urandom_range(0, 255);
                case ($urandom_range(0, 2))
                    0:       add_pct = 30;
                    1:       add_pct = 45;
                    default: add_pct = 65;
                endcase
            end
            issue(pick_command(), pick_address());
        end
        start <= 1'b0;

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/cbt_pkg.sv
rtl/core/cbt_mem.sv
rtl/core/code_breakpoint_table.sv
test/tb.sv
